// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define FCA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

`define FCA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define FCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define FCA_ASSERT(lbl, clk, rst_n, prop)
`define FCA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define FCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/fca_pkg.sv -----
`default_nettype none

package fca_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_CRC  = 2'd1;
	localparam logic [1:0] MODE_XOR  = 2'd2;
	localparam logic [1:0] MODE_SUM  = 2'd3;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_checksum;
		logic       out_last;
	} fca_word_t;

	typedef struct packed {
		fca_word_t [2:0] words;
		logic [1:0]      count;
	} fca_burst_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fca_in_if.sv -----
`default_nettype none

interface fca_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       frame_end;

	modport source(output valid, data_byte, has_byte, frame_end, input ready);
	modport sink(input valid, data_byte, has_byte, frame_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/fca_out_if.sv -----
`default_nettype none

interface fca_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_checksum;
	logic       out_last;

	modport source(output valid, out_byte, is_checksum, out_last, input ready);
	modport sink(input valid, out_byte, is_checksum, out_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/fca_accum.sv -----
`default_nettype none
`include "assert_macros.svh"

module fca_accum (
	input  wire logic            clk,
	input  wire logic            arst_n,
	fca_in_if.sink               ingress,
	input  wire logic [1:0]      mode,
	output fca_pkg::fca_burst_t  burst,
	output logic                 burst_valid,
	input  wire logic            burst_take
);
	import fca_pkg::*;

	logic [15:0] crc_q;
	logic [7:0]  xor_q;
	logic [7:0]  sum_q;
	fca_burst_t  burst_s1;
	logic        valid_s1;

	logic        accept;
	logic [15:0] crc_next;
	logic [7:0]  xor_next;
	logic [7:0]  sum_next;
	fca_burst_t  burst_d;
	logic [1:0]  base;

	assign ingress.ready = !valid_s1 || burst_take;
	assign accept        = ingress.valid && ingress.ready;

	always_comb begin
		if (ingress.has_byte) begin
			crc_next = crc_byte(crc_q, ingress.data_byte);
			xor_next = xor_q ^ ingress.data_byte;
			sum_next = sum_q + ingress.data_byte;
		end else begin
			crc_next = crc_q;
			xor_next = xor_q;
			sum_next = sum_q;
		end
	end

	always_comb begin
		burst_d = '0;
		base    = {1'b0, ingress.has_byte};
		if (ingress.has_byte) begin
			burst_d.words[0] = '{out_byte: ingress.data_byte, is_checksum: 1'b0,
				out_last: ingress.frame_end && (mode == MODE_NONE)};
		end
		if (ingress.frame_end) begin
			unique case (mode)
				MODE_CRC: begin
					burst_d.words[base] = '{out_byte: crc_next[7:0], is_checksum: 1'b1,
						out_last: 1'b0};
					burst_d.words[base + 2'd1] = '{out_byte: crc_next[15:8], is_checksum: 1'b1,
						out_last: 1'b1};
					burst_d.count = base + 2'd2;
				end
				MODE_XOR: begin
					burst_d.words[base] = '{out_byte: xor_next, is_checksum: 1'b1, out_last: 1'b1};
					burst_d.count = base + 2'd1;
				end
				MODE_SUM: begin
					burst_d.words[base] = '{out_byte: sum_next, is_checksum: 1'b1, out_last: 1'b1};
					burst_d.count = base + 2'd1;
				end
				MODE_NONE: begin
					burst_d.count = base;
				end
			endcase
		end else begin
			burst_d.count = base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= CRC_INIT;
			xor_q    <= '0;
			sum_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (ingress.frame_end) begin
					crc_q <= CRC_INIT;
					xor_q <= '0;
					sum_q <= '0;
				end else begin
					crc_q <= crc_next;
					xor_q <= xor_next;
					sum_q <= sum_next;
				end
				valid_s1 <= (burst_d.count != 2'd0);
			end else if (burst_take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			burst_s1 <= burst_d;
		end
	end

	assign burst       = burst_s1;
	assign burst_valid = valid_s1;

	`FCA_ASSERT_NEXT(a_reset_after_close, clk, arst_n,
		accept && ingress.frame_end, crc_q == CRC_INIT && xor_q == 8'h00 && sum_q == 8'h00)
	`FCA_ASSERT_NEXT(a_s1_holds, clk, arst_n,
		valid_s1 && !burst_take, valid_s1 && $stable(burst_s1))
	`FCA_ASSERT_IMPL(a_full_burst_order, clk, arst_n,
		valid_s1 && burst_s1.count == 2'd3,
		!burst_s1.words[0].is_checksum && burst_s1.words[1].is_checksum)

endmodule

`default_nettype wire

// ----- rtl/core/fca_emitter.sv -----
`default_nettype none
`include "assert_macros.svh"

module fca_emitter (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire fca_pkg::fca_burst_t  burst,
	input  wire logic                 burst_valid,
	output logic                      burst_take,
	fca_out_if.source                 egress
);
	import fca_pkg::*;

	fca_word_t [2:0] words_q;
	logic [1:0]      cnt_q;
	logic            take;

	assign egress.valid       = (cnt_q != 2'd0);
	assign egress.out_byte    = words_q[0].out_byte;
	assign egress.is_checksum = words_q[0].is_checksum;
	assign egress.out_last    = words_q[0].out_last;

	assign take       = egress.valid && egress.ready;
	assign burst_take = burst_valid && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && take));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			if (burst_take) begin
				cnt_q <= burst.count;
			end else if (take) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (burst_take) begin
			words_q <= burst.words;
		end else if (take) begin
			words_q[0] <= words_q[1];
			words_q[1] <= words_q[2];
		end
	end

	`FCA_ASSERT_IMPL(a_last_ends_burst, clk, arst_n,
		egress.valid && words_q[0].out_last, cnt_q == 2'd1)

endmodule

`default_nettype wire

// ----- rtl/core/frame_checksum_appender.sv -----
`default_nettype none

// Channel   Role    Word fields
// ingress   sink    data_byte[7:0], has_byte, frame_end
// egress    source  out_byte[7:0], is_checksum, out_last
// cfg       write   cfg_we, cfg_wdata[1:0] (checksum mode)
//
// One input word is taken per cycle while the input is not stalled; its result words
// (zero to three) pass through stage one into the output register and leave one per
// cycle while the output is ready. A closing word with a CRC checksum yields up to
// three output words, so the input can stall behind it.
// The CRC byte update is the longest path, between the input and the result register.
// A stalled output holds one pending burst in stage one before the input stalls.
// Reset clears the mode, the accumulators and all valid state; no clearing pass.

module frame_checksum_appender (
	input  wire logic       clk,
	input  wire logic       arst_n,
	fca_in_if.sink          ingress,
	fca_out_if.source       egress,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_wdata
);
	import fca_pkg::*;

	logic [1:0] mode_q;
	fca_burst_t burst;
	logic       burst_valid;
	logic       burst_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NONE;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	fca_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.ingress     (ingress),
		.mode        (mode_q),
		.burst       (burst),
		.burst_valid (burst_valid),
		.burst_take  (burst_take)
	);

	fca_emitter u_emitter (
		.clk         (clk),
		.arst_n      (arst_n),
		.burst       (burst),
		.burst_valid (burst_valid),
		.burst_take  (burst_take),
		.egress      (egress)
	);

endmodule

`default_nettype wire
